// ===== design/tskt_pkg.sv =====
// ----------------------------------------------------------------------------
// tskt_pkg: shared types and constants of the time sorted keyed table
// Opcodes, status codes, entry layout, controller/datapath bundles and the
// key normalization function.
// ----------------------------------------------------------------------------
package tskt_pkg;

	localparam int CAPACITY_DEFAULT = 16;
	localparam int HOURS            = 24;
	localparam int MINUTES          = 60;
	localparam int KEY_BYTES        = 19;
	localparam int KEY_BITS         = KEY_BYTES * 8;

	typedef enum logic [1:0] {
		OP_INSERT = 2'd0,
		OP_DELETE = 2'd1,
		OP_SHOW   = 2'd2
	} op_t;

	typedef enum logic [2:0] {
		ST_INSERTED  = 3'd0,
		ST_EXISTS    = 3'd1,
		ST_FULL      = 3'd2,
		ST_REMOVED   = 3'd3,
		ST_NOT_FOUND = 3'd4,
		ST_ENTRY     = 3'd5,
		ST_EMPTY     = 3'd6,
		ST_BAD_TIME  = 3'd7
	} status_t;

	typedef enum logic [1:0] {
		RD_IDX,
		RD_PREV,
		RD_NEXT
	} rd_sel_t;

	typedef struct packed {
		logic [63:0] w0;
		logic [63:0] w1;
		logic [23:0] w2;
		logic [4:0]  hour;
		logic [5:0]  minute;
	} entry_t;

	typedef struct packed {
		logic    in_ready;
		logic    load;
		logic    scan_init;
		logic    scan_upd;
		logic    idx_clr;
		logic    idx_ld_count;
		logic    idx_ld_pos;
		logic    idx_inc;
		logic    idx_dec;
		logic    rd_en;
		rd_sel_t rd_sel;
		logic    wr_shift;
		logic    wr_new;
		logic    cnt_inc;
		logic    cnt_dec;
		logic    emit;
		logic    emit_entry;
		logic    emit_last;
		status_t emit_status;
	} dp_cmd_t;

	typedef struct packed {
		logic       in_valid;
		logic [1:0] op;
		logic       bad_time;
		logic       count_zero;
		logic       full;
		logic       found;
		logic       match;
		logic       idx_last;
		logic       idx_gt_pos;
		logic       idx_more;
		logic       out_free;
	} dp_stat_t;

	// Zero every byte that follows the first zero byte.
	function automatic logic [KEY_BITS-1:0] normalize_key(input logic [KEY_BITS-1:0] raw);
		logic [KEY_BITS-1:0] res;
		logic                keep;
		res = '0;
		for (int i = 0; i < KEY_BYTES; i++) begin
			keep = 1'b1;
			for (int j = 0; j < i; j++) begin
				keep = keep & (|raw[j*8 +: 8]);
			end
			if (keep) begin
				res[i*8 +: 8] = raw[i*8 +: 8];
			end
		end
		return res;
	endfunction

endpackage

// ===== design/tskt_ifs.sv =====
// ----------------------------------------------------------------------------
// tskt_ifs: request and response channels of the time sorted keyed table
// Valid/ready channels; a transfer completes when valid and ready are high.
// ----------------------------------------------------------------------------
interface tskt_req_if;
	logic        valid;
	logic        ready;
	logic [1:0]  cmd;
	logic [63:0] key_word0;
	logic [63:0] key_word1;
	logic [23:0] key_word2;
	logic [4:0]  hour_in;
	logic [5:0]  minute_in;

	modport source (
		output valid, cmd, key_word0, key_word1, key_word2, hour_in, minute_in,
		input  ready
	);
	modport sink (
		input  valid, cmd, key_word0, key_word1, key_word2, hour_in, minute_in,
		output ready
	);
endinterface

interface tskt_rsp_if;
	logic        valid;
	logic        ready;
	logic [2:0]  status;
	logic [63:0] out_word0;
	logic [63:0] out_word1;
	logic [23:0] out_word2;
	logic [4:0]  hour_out;
	logic [5:0]  minute_out;
	logic        last;

	modport source (
		output valid, status, out_word0, out_word1, out_word2, hour_out, minute_out, last,
		input  ready
	);
	modport sink (
		input  valid, status, out_word0, out_word1, out_word2, hour_out, minute_out, last,
		output ready
	);
endinterface

// ===== design/time_sorted_keyed_table_top.sv =====
// ----------------------------------------------------------------------------
// time_sorted_keyed_table_top: table of named entries kept in time order
// Insert, delete by name and list of up to CAPACITY entries.
// ----------------------------------------------------------------------------
// One request is handled at a time. All table walks go through the single
// registered read port of the entry memory; each entry visit is a read state
// followed by a compare, shift or output state. A search stops at a match or
// at the last entry, an insert or delete then shifts the entries behind the
// position, and a listing also waits out any output stall. A finished response
// sits in an output register, so the next request is taken while it waits.
// No clearing pass is needed after reset.
module time_sorted_keyed_table_top #(
	parameter int CAPACITY = tskt_pkg::CAPACITY_DEFAULT
) (
	input logic        clk,
	input logic        arst_n,
	tskt_req_if.sink   req,
	tskt_rsp_if.source rsp
);

	tskt_pkg::dp_cmd_t  cmd;
	tskt_pkg::dp_stat_t stat;

	tskt_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.stat   (stat),
		.cmd    (cmd)
	);

	tskt_datapath #(
		.CAPACITY (CAPACITY)
	) u_datapath (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req),
		.rsp    (rsp),
		.cmd    (cmd),
		.stat   (stat)
	);

endmodule

// ===== design/tskt_datapath.sv =====
// ----------------------------------------------------------------------------
// tskt_datapath: entry memory, walk counters and response register
// Holds the captured request, the sorted entry memory with a registered read
// port, the index/position/count registers and the output register.
// ----------------------------------------------------------------------------
module tskt_datapath #(
	parameter int CAPACITY = tskt_pkg::CAPACITY_DEFAULT
) (
	input  logic               clk,
	input  logic               arst_n,
	tskt_req_if.sink           req,
	tskt_rsp_if.source         rsp,
	input  tskt_pkg::dp_cmd_t  cmd,
	output tskt_pkg::dp_stat_t stat
);

	localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
	localparam int CW = $clog2(CAPACITY + 1);

	tskt_pkg::entry_t mem [CAPACITY];
	tskt_pkg::entry_t new_q;
	tskt_pkg::entry_t rd_q;
	tskt_pkg::entry_t wdata;
	tskt_pkg::entry_t out_entry_q;

	logic [tskt_pkg::KEY_BITS-1:0] key_norm;
	logic [1:0]    op_q;
	logic [CW-1:0] count_q;
	logic [CW-1:0] idx_q;
	logic [CW-1:0] pos_q;
	logic          found_q;
	logic          pos_set_q;
	logic [CW-1:0] raddr_full;
	logic [AW-1:0] raddr;
	logic [AW-1:0] waddr;
	logic          we;
	logic [CW:0]   idx_next;
	logic          match;
	logic          less;
	logic          out_valid_q;
	logic [2:0]    out_status_q;
	logic          out_last_q;

	always_comb begin
		key_norm = tskt_pkg::normalize_key({req.key_word2, req.key_word1, req.key_word0});
		idx_next = {1'b0, idx_q} + {{CW{1'b0}}, 1'b1};
		match    = (rd_q.w0 == new_q.w0) && (rd_q.w1 == new_q.w1) && (rd_q.w2 == new_q.w2);
		less     = {new_q.hour, new_q.minute} < {rd_q.hour, rd_q.minute};
		case (cmd.rd_sel)
			tskt_pkg::RD_IDX:  raddr_full = idx_q;
			tskt_pkg::RD_PREV: raddr_full = idx_q - {{(CW-1){1'b0}}, 1'b1};
			tskt_pkg::RD_NEXT: raddr_full = idx_next[CW-1:0];
			default:           raddr_full = idx_q;
		endcase
		raddr = raddr_full[AW-1:0];
		we    = cmd.wr_shift | cmd.wr_new;
		waddr = cmd.wr_new ? pos_q[AW-1:0] : idx_q[AW-1:0];
		wdata = cmd.wr_new ? new_q : rd_q;
	end

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (cmd.rd_en) begin
			rd_q <= mem[raddr];
		end
		if (cmd.load) begin
			op_q         <= req.cmd;
			new_q.w0     <= key_norm[63:0];
			new_q.w1     <= key_norm[127:64];
			new_q.w2     <= key_norm[151:128];
			new_q.hour   <= req.hour_in;
			new_q.minute <= req.minute_in;
		end
		if (cmd.emit) begin
			out_status_q <= cmd.emit_status;
			out_last_q   <= cmd.emit_last;
			out_entry_q  <= cmd.emit_entry ? rd_q : '0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q     <= '0;
			idx_q       <= '0;
			pos_q       <= '0;
			found_q     <= 1'b0;
			pos_set_q   <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (cmd.idx_clr) begin
				idx_q <= '0;
			end else if (cmd.idx_ld_count) begin
				idx_q <= count_q;
			end else if (cmd.idx_ld_pos) begin
				idx_q <= pos_q;
			end else if (cmd.idx_inc) begin
				idx_q <= idx_next[CW-1:0];
			end else if (cmd.idx_dec) begin
				idx_q <= idx_q - {{(CW-1){1'b0}}, 1'b1};
			end
			if (cmd.scan_init) begin
				found_q   <= 1'b0;
				pos_set_q <= 1'b0;
				pos_q     <= count_q;
			end else if (cmd.scan_upd) begin
				if (match) begin
					found_q <= 1'b1;
					pos_q   <= idx_q;
				end else if (less && !pos_set_q) begin
					pos_q     <= idx_q;
					pos_set_q <= 1'b1;
				end
			end
			if (cmd.cnt_inc) begin
				count_q <= count_q + {{(CW-1){1'b0}}, 1'b1};
			end else if (cmd.cnt_dec) begin
				count_q <= count_q - {{(CW-1){1'b0}}, 1'b1};
			end
			if (cmd.emit) begin
				out_valid_q <= 1'b1;
			end else if (rsp.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_comb begin
		stat.in_valid   = req.valid;
		stat.op         = op_q;
		stat.bad_time   = (new_q.hour >= 5'(tskt_pkg::HOURS)) ||
		                  (new_q.minute >= 6'(tskt_pkg::MINUTES));
		stat.count_zero = (count_q == '0);
		stat.full       = (count_q >= CW'(CAPACITY));
		stat.found      = found_q;
		stat.match      = match;
		stat.idx_last   = (idx_next == {1'b0, count_q});
		stat.idx_gt_pos = (idx_q > pos_q);
		stat.idx_more   = (idx_next < {1'b0, count_q});
		stat.out_free   = !out_valid_q || rsp.ready;
	end

	assign req.ready      = cmd.in_ready;
	assign rsp.valid      = out_valid_q;
	assign rsp.status     = out_status_q;
	assign rsp.out_word0  = out_entry_q.w0;
	assign rsp.out_word1  = out_entry_q.w1;
	assign rsp.out_word2  = out_entry_q.w2;
	assign rsp.hour_out   = out_entry_q.hour;
	assign rsp.minute_out = out_entry_q.minute;
	assign rsp.last       = out_last_q;

endmodule

// ===== design/tskt_ctrl.sv =====
// ----------------------------------------------------------------------------
// tskt_ctrl: sequencer of the time sorted keyed table
// Walks the entry memory for search, shift and listing and issues one
// datapath command per cycle.
// ----------------------------------------------------------------------------
module tskt_ctrl (
	input  logic               clk,
	input  logic               arst_n,
	input  tskt_pkg::dp_stat_t stat,
	output tskt_pkg::dp_cmd_t  cmd
);

	typedef enum logic [3:0] {
		S_IDLE,
		S_DISPATCH,
		S_SCAN_RD,
		S_SCAN_CMP,
		S_DECIDE,
		S_INS_CHK,
		S_INS_SHIFT,
		S_DEL_CHK,
		S_DEL_SHIFT,
		S_LIST_RD,
		S_LIST_OUT,
		S_EMIT
	} state_t;

	state_t             state_q;
	state_t             state_d;
	tskt_pkg::status_t  status_q;
	tskt_pkg::status_t  status_d;

	always_comb begin
		cmd         = '0;
		cmd.rd_sel  = tskt_pkg::RD_IDX;
		cmd.emit_status = status_q;
		state_d     = state_q;
		status_d    = status_q;
		case (state_q)
			S_IDLE: begin
				cmd.in_ready = 1'b1;
				cmd.load     = stat.in_valid;
				if (stat.in_valid) begin
					state_d = S_DISPATCH;
				end
			end
			S_DISPATCH: begin
				case (stat.op)
					tskt_pkg::OP_INSERT, tskt_pkg::OP_DELETE: begin
						if ((stat.op == tskt_pkg::OP_INSERT) && stat.bad_time) begin
							status_d = tskt_pkg::ST_BAD_TIME;
							state_d  = S_EMIT;
						end else begin
							cmd.scan_init = 1'b1;
							cmd.idx_clr   = 1'b1;
							state_d       = stat.count_zero ? S_DECIDE : S_SCAN_RD;
						end
					end
					tskt_pkg::OP_SHOW: begin
						if (stat.count_zero) begin
							status_d = tskt_pkg::ST_EMPTY;
							state_d  = S_EMIT;
						end else begin
							cmd.idx_clr = 1'b1;
							state_d     = S_LIST_RD;
						end
					end
					default: state_d = S_IDLE;
				endcase
			end
			S_SCAN_RD: begin
				cmd.rd_en = 1'b1;
				state_d   = S_SCAN_CMP;
			end
			S_SCAN_CMP: begin
				cmd.scan_upd = 1'b1;
				if (stat.match || stat.idx_last) begin
					state_d = S_DECIDE;
				end else begin
					cmd.idx_inc = 1'b1;
					state_d     = S_SCAN_RD;
				end
			end
			S_DECIDE: begin
				if (stat.op == tskt_pkg::OP_INSERT) begin
					if (stat.found) begin
						status_d = tskt_pkg::ST_EXISTS;
						state_d  = S_EMIT;
					end else if (stat.full) begin
						status_d = tskt_pkg::ST_FULL;
						state_d  = S_EMIT;
					end else begin
						cmd.idx_ld_count = 1'b1;
						state_d          = S_INS_CHK;
					end
				end else begin
					if (stat.found) begin
						cmd.idx_ld_pos = 1'b1;
						state_d        = S_DEL_CHK;
					end else begin
						status_d = tskt_pkg::ST_NOT_FOUND;
						state_d  = S_EMIT;
					end
				end
			end
			S_INS_CHK: begin
				if (stat.idx_gt_pos) begin
					cmd.rd_en  = 1'b1;
					cmd.rd_sel = tskt_pkg::RD_PREV;
					state_d    = S_INS_SHIFT;
				end else begin
					cmd.wr_new  = 1'b1;
					cmd.cnt_inc = 1'b1;
					status_d    = tskt_pkg::ST_INSERTED;
					state_d     = S_EMIT;
				end
			end
			S_INS_SHIFT: begin
				cmd.wr_shift = 1'b1;
				cmd.idx_dec  = 1'b1;
				state_d      = S_INS_CHK;
			end
			S_DEL_CHK: begin
				if (stat.idx_more) begin
					cmd.rd_en  = 1'b1;
					cmd.rd_sel = tskt_pkg::RD_NEXT;
					state_d    = S_DEL_SHIFT;
				end else begin
					cmd.cnt_dec = 1'b1;
					status_d    = tskt_pkg::ST_REMOVED;
					state_d     = S_EMIT;
				end
			end
			S_DEL_SHIFT: begin
				cmd.wr_shift = 1'b1;
				cmd.idx_inc  = 1'b1;
				state_d      = S_DEL_CHK;
			end
			S_LIST_RD: begin
				cmd.rd_en = 1'b1;
				state_d   = S_LIST_OUT;
			end
			S_LIST_OUT: begin
				if (stat.out_free) begin
					cmd.emit        = 1'b1;
					cmd.emit_entry  = 1'b1;
					cmd.emit_last   = stat.idx_last;
					cmd.emit_status = tskt_pkg::ST_ENTRY;
					if (stat.idx_last) begin
						state_d = S_IDLE;
					end else begin
						cmd.idx_inc = 1'b1;
						state_d     = S_LIST_RD;
					end
				end
			end
			S_EMIT: begin
				if (stat.out_free) begin
					cmd.emit      = 1'b1;
					cmd.emit_last = 1'b1;
					state_d       = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= S_IDLE;
			status_q <= tskt_pkg::ST_INSERTED;
		end else begin
			state_q  <= state_d;
			status_q <= status_d;
		end
	end

endmodule

// ===== design/tskt_checker.sv =====
// ----------------------------------------------------------------------------
// tskt_checker: port level checks of the time sorted keyed table
// Response ordering, payload and request acceptance rules seen at the ports.
// ----------------------------------------------------------------------------
module tskt_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        req_valid,
	input logic        req_ready,
	input logic        rsp_valid,
	input logic        rsp_ready,
	input logic [2:0]  rsp_status,
	input logic [63:0] rsp_word0,
	input logic [63:0] rsp_word1,
	input logic [23:0] rsp_word2,
	input logic [4:0]  rsp_hour,
	input logic [5:0]  rsp_minute,
	input logic        rsp_last
);

	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_status) && $stable(rsp_last)
			&& $stable(rsp_word0) && $stable(rsp_hour) && $stable(rsp_minute))
		else $error("response changed while stalled");

	a_status_last: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && (rsp_status != tskt_pkg::ST_ENTRY) |-> rsp_last)
		else $error("status response without last");

	a_status_zero: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && (rsp_status != tskt_pkg::ST_ENTRY) |->
			(rsp_word0 == '0) && (rsp_word1 == '0) && (rsp_word2 == '0)
			&& (rsp_hour == '0) && (rsp_minute == '0))
		else $error("status response with nonzero payload");

	a_entry_time: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && (rsp_status == tskt_pkg::ST_ENTRY) |->
			(rsp_hour < 5'(tskt_pkg::HOURS)) && (rsp_minute < 6'(tskt_pkg::MINUTES)))
		else $error("listed entry with invalid time");

	a_busy_after_req: assert property (@(posedge clk) disable iff (!arst_n)
		req_valid && req_ready |=> !req_ready)
		else $error("request taken while previous one in progress");

endmodule

bind time_sorted_keyed_table_top tskt_checker u_tskt_checker (
	.clk        (clk),
	.arst_n     (arst_n),
	.req_valid  (req.valid),
	.req_ready  (req.ready),
	.rsp_valid  (rsp.valid),
	.rsp_ready  (rsp.ready),
	.rsp_status (rsp.status),
	.rsp_word0  (rsp.out_word0),
	.rsp_word1  (rsp.out_word1),
	.rsp_word2  (rsp.out_word2),
	.rsp_hour   (rsp.hour_out),
	.rsp_minute (rsp.minute_out),
	.rsp_last   (rsp.last)
);

// ===== tb/sv/testbench.sv =====
// ----------------------------------------------------------------------------
// testbench: time sorted keyed table
// Sends insert, delete, list and unused-opcode requests with random gaps on
// both channels. A local model of the time ordered table predicts every
// response, and each response is compared field by field in arrival order.
// ----------------------------------------------------------------------------
module testbench;

	localparam logic [1:0] OP_UNUSED    = 2'd3;
	localparam int         ENTRY_SLOTS  = tskt_pkg::CAPACITY_DEFAULT;
	localparam int         CYCLE_LIMIT  = 400000;
	localparam int         DRAIN_CYCLES = 100;

	typedef logic [tskt_pkg::KEY_BITS-1:0] name_bits_t;

	typedef struct {
		tskt_pkg::status_t status;
		tskt_pkg::entry_t  body;
		logic              last;
	} reply_t;

	logic clk = 1'b0;
	logic arst_n;

	tskt_req_if req_ch();
	tskt_rsp_if rsp_ch();

	time_sorted_keyed_table_top uut (
		.clk(clk),
		.arst_n(arst_n),
		.req(req_ch),
		.rsp(rsp_ch)
	);

	tskt_pkg::entry_t roster [ENTRY_SLOTS];
	int     roster_count = 0;
	reply_t reply_q [$];
	int     errors = 0;
	int     cycles = 0;
	int     results_seen = 0;
	int     full_hits = 0;
	int     op_counts [4] = '{0, 0, 0, 0};
	bit     req_idle_on = 1'b1;
	bit     rsp_idle_on = 1'b1;
	int     rsp_hold = 0;

	initial forever #5 clk = ~clk;

	initial begin
		while (cycles < CYCLE_LIMIT) begin
			@(posedge clk);
			cycles++;
		end
		$display("time_sorted_keyed_table_top verification failed");
		$finish;
	end

	task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
		$display("MISMATCH @%0t %s: got %h expected %h", $time, what, got, want);
		errors++;
	endtask

	function automatic name_bits_t trim_name(name_bits_t raw);
		name_bits_t res;
		bit         ended;
		res = '0;
		ended = 1'b0;
		for (int i = 0; i < tskt_pkg::KEY_BYTES; i++) begin
			if (!ended) res[i*8 +: 8] = raw[i*8 +: 8];
			if (raw[i*8 +: 8] == 8'h00) ended = 1'b1;
		end
		return res;
	endfunction

	function automatic int roster_find(name_bits_t nm);
		for (int i = 0; i < roster_count; i++) begin
			if ({roster[i].w2, roster[i].w1, roster[i].w0} == nm) return i;
		end
		return -1;
	endfunction

	function automatic void push_reply(tskt_pkg::status_t st, tskt_pkg::entry_t body,
			logic last);
		reply_t r;
		r.status = st;
		r.body = body;
		r.last = last;
		reply_q.push_back(r);
	endfunction

	function automatic void schedule_update(logic [1:0] op, name_bits_t raw,
			logic [4:0] hr, logic [5:0] mn);
		name_bits_t       nm;
		int               hit;
		int               pos;
		tskt_pkg::entry_t fresh;
		nm = trim_name(raw);
		hit = roster_find(nm);
		fresh = '{w0: nm[63:0], w1: nm[127:64], w2: nm[151:128], hour: hr, minute: mn};
		case (op)
			tskt_pkg::OP_INSERT: begin
				if (hr >= tskt_pkg::HOURS || mn >= tskt_pkg::MINUTES) begin
					push_reply(tskt_pkg::ST_BAD_TIME, '0, 1'b1);
				end else if (hit >= 0) begin
					push_reply(tskt_pkg::ST_EXISTS, '0, 1'b1);
				end else if (roster_count >= ENTRY_SLOTS) begin
					push_reply(tskt_pkg::ST_FULL, '0, 1'b1);
					full_hits++;
				end else begin
					pos = 0;
					while (pos < roster_count &&
							{hr, mn} >= {roster[pos].hour, roster[pos].minute}) pos++;
					for (int i = roster_count; i > pos; i--) roster[i] = roster[i-1];
					roster[pos] = fresh;
					roster_count++;
					push_reply(tskt_pkg::ST_INSERTED, '0, 1'b1);
				end
			end
			tskt_pkg::OP_DELETE: begin
				if (hit < 0) begin
					push_reply(tskt_pkg::ST_NOT_FOUND, '0, 1'b1);
				end else begin
					for (int i = hit; i + 1 < roster_count; i++) roster[i] = roster[i+1];
					roster_count--;
					push_reply(tskt_pkg::ST_REMOVED, '0, 1'b1);
				end
			end
			tskt_pkg::OP_SHOW: begin
				if (roster_count == 0) begin
					push_reply(tskt_pkg::ST_EMPTY, '0, 1'b1);
				end else begin
					for (int i = 0; i < roster_count; i++)
						push_reply(tskt_pkg::ST_ENTRY, roster[i], i == roster_count - 1);
				end
			end
			default: ;
		endcase
	endfunction

	always @(negedge clk) begin
		if (rsp_hold > 0) begin
			rsp_ch.ready <= 1'b0;
			rsp_hold--;
		end else begin
			rsp_ch.ready <= 1'b1;
		end
	end

	always @(posedge clk) begin
		reply_t want;
		if (arst_n === 1'b1 && rsp_ch.valid === 1'b1 && rsp_ch.ready === 1'b1) begin
			results_seen++;
			rsp_hold = rsp_idle_on ? $urandom_range(0, 5) : 0;
			if (reply_q.size() == 0) begin
				report_mismatch("unexpected response status", 64'(rsp_ch.status), 64'd0);
			end else begin
				want = reply_q.pop_front();
				if (rsp_ch.status !== want.status)
					report_mismatch("status", 64'(rsp_ch.status), 64'(want.status));
				if (rsp_ch.out_word0 !== want.body.w0)
					report_mismatch("out_word0", rsp_ch.out_word0, want.body.w0);
				if (rsp_ch.out_word1 !== want.body.w1)
					report_mismatch("out_word1", rsp_ch.out_word1, want.body.w1);
				if (rsp_ch.out_word2 !== want.body.w2)
					report_mismatch("out_word2", 64'(rsp_ch.out_word2), 64'(want.body.w2));
				if (rsp_ch.hour_out !== want.body.hour)
					report_mismatch("hour_out", 64'(rsp_ch.hour_out), 64'(want.body.hour));
				if (rsp_ch.minute_out !== want.body.minute)
					report_mismatch("minute_out", 64'(rsp_ch.minute_out),
						64'(want.body.minute));
				if (rsp_ch.last !== want.last)
					report_mismatch("last", 64'(rsp_ch.last), 64'(want.last));
			end
		end
	end

	task automatic send_request(logic [1:0] op, name_bits_t raw, int hr, int mn);
		int         gap;
		logic [4:0] hr_b;
		logic [5:0] mn_b;
		hr_b = 5'(hr);
		mn_b = 6'(mn);
		gap = req_idle_on ? $urandom_range(0, 5) : 0;
		@(negedge clk);
		if (gap > 0) begin
			req_ch.valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		req_ch.valid     <= 1'b1;
		req_ch.cmd       <= op;
		req_ch.key_word0 <= raw[63:0];
		req_ch.key_word1 <= raw[127:64];
		req_ch.key_word2 <= raw[151:128];
		req_ch.hour_in   <= hr_b;
		req_ch.minute_in <= mn_b;
		do @(posedge clk); while (req_ch.ready !== 1'b1);
		schedule_update(op, raw, hr_b, mn_b);
		op_counts[op]++;
	endtask

	function automatic name_bits_t text_name(string s);
		name_bits_t nm;
		nm = '0;
		for (int i = 0; i < s.len() && i < tskt_pkg::KEY_BYTES; i++) nm[i*8 +: 8] = s[i];
		return nm;
	endfunction

	function automatic name_bits_t random_name();
		name_bits_t nm;
		int         len;
		nm = '0;
		len = ($urandom_range(0, 3) == 0) ? tskt_pkg::KEY_BYTES :
			$urandom_range(0, tskt_pkg::KEY_BYTES);
		for (int i = 0; i < len; i++) nm[i*8 +: 8] = 8'($urandom_range(1, 255));
		return nm;
	endfunction

	function automatic name_bits_t present_name();
		tskt_pkg::entry_t e;
		e = roster[$urandom_range(0, roster_count - 1)];
		return {e.w2, e.w1, e.w0};
	endfunction

	// fill bytes past the terminator with junk, on about one call in three
	function automatic name_bits_t soil_name(name_bits_t nm);
		name_bits_t res;
		bit         ended;
		res = nm;
		ended = 1'b0;
		if ($urandom_range(0, 2) != 0) return nm;
		for (int i = 0; i < tskt_pkg::KEY_BYTES; i++) begin
			if (ended) res[i*8 +: 8] = 8'($urandom);
			else if (nm[i*8 +: 8] == 8'h00) ended = 1'b1;
		end
		return res;
	endfunction

	task automatic random_time(output int hr, output int mn);
		int pick;
		pick = $urandom_range(0, 19);
		if (pick < 2) begin
			hr = $urandom_range(tskt_pkg::HOURS, 31);
			mn = $urandom_range(0, 63);
		end else if (pick < 3) begin
			hr = $urandom_range(0, tskt_pkg::HOURS - 1);
			mn = $urandom_range(tskt_pkg::MINUTES, 63);
		end else if (pick < 4) begin
			hr = $urandom_range(0, 1) ? tskt_pkg::HOURS - 1 : 0;
			mn = (hr == 0) ? 0 : tskt_pkg::MINUTES - 1;
		end else if (pick < 10) begin
			hr = $urandom_range(8, 9);
			mn = $urandom_range(0, 1) ? 30 : 0;
		end else begin
			hr = $urandom_range(0, tskt_pkg::HOURS - 1);
			mn = $urandom_range(0, tskt_pkg::MINUTES - 1);
		end
	endtask

	task automatic random_request(int insert_pct, int delete_pct);
		int         roll;
		int         hr;
		int         mn;
		name_bits_t nm;
		roll = $urandom_range(0, 99);
		random_time(hr, mn);
		if (roll < insert_pct) begin
			nm = (roster_count > 0 && $urandom_range(0, 7) == 0) ? present_name() : random_name();
			send_request(tskt_pkg::OP_INSERT, soil_name(nm), hr, mn);
		end else if (roll < insert_pct + delete_pct) begin
			nm = (roster_count > 0 && $urandom_range(0, 5) != 0) ? present_name() : random_name();
			send_request(tskt_pkg::OP_DELETE, soil_name(nm), hr, mn);
		end else if (roll < 97) begin
			send_request(tskt_pkg::OP_SHOW, random_name(), hr, mn);
		end else begin
			send_request(OP_UNUSED, random_name(), hr, mn);
		end
	endtask

	task automatic test_empty_table();
		send_request(tskt_pkg::OP_SHOW, '0, 0, 0);
		send_request(tskt_pkg::OP_DELETE, text_name("nobody"), 0, 0);
		send_request(OP_UNUSED, '1, 31, 63);
		send_request(tskt_pkg::OP_SHOW, '1, 31, 63);
	endtask

	task automatic test_time_limits();
		send_request(tskt_pkg::OP_INSERT, text_name("late"), 24, 0);
		send_request(tskt_pkg::OP_INSERT, text_name("late"), 31, 63);
		send_request(tskt_pkg::OP_INSERT, text_name("late"), 0, 60);
		send_request(tskt_pkg::OP_INSERT, text_name("late"), 23, 63);
		send_request(tskt_pkg::OP_INSERT, text_name("early"), 0, 0);
		send_request(tskt_pkg::OP_INSERT, text_name("early"), 24, 0);
		send_request(tskt_pkg::OP_INSERT, '1, 23, 59);
		send_request(tskt_pkg::OP_INSERT, '0, 12, 0);
		send_request(tskt_pkg::OP_SHOW, '0, 0, 0);
	endtask

	task automatic test_name_ending();
		name_bits_t nm;
		nm = text_name("AB");
		nm[tskt_pkg::KEY_BITS-1:24] = '1;
		send_request(tskt_pkg::OP_INSERT, nm, 12, 0);
		send_request(tskt_pkg::OP_INSERT, text_name("AB"), 5, 0);
		send_request(tskt_pkg::OP_DELETE, '0, 0, 0);
		nm[tskt_pkg::KEY_BITS-1:24] = {16{8'h5a}};
		send_request(tskt_pkg::OP_DELETE, nm, 7, 7);
		send_request(tskt_pkg::OP_DELETE, text_name("AB"), 0, 0);
		send_request(tskt_pkg::OP_SHOW, '0, 0, 0);
	endtask

	task automatic test_equal_times();
		send_request(tskt_pkg::OP_INSERT, text_name("t1"), 12, 0);
		send_request(tskt_pkg::OP_INSERT, text_name("t4"), 12, 1);
		send_request(tskt_pkg::OP_INSERT, text_name("t2"), 12, 0);
		send_request(tskt_pkg::OP_INSERT, text_name("t0"), 11, 59);
		send_request(tskt_pkg::OP_INSERT, text_name("t3"), 12, 0);
		send_request(tskt_pkg::OP_SHOW, '0, 0, 0);
	endtask

	task automatic test_fill_to_full();
		while (roster_count < ENTRY_SLOTS) random_request(85, 5);
		send_request(tskt_pkg::OP_INSERT, soil_name(random_name()), 9, 30);
		send_request(tskt_pkg::OP_INSERT, present_name(), 24, 0);
		send_request(tskt_pkg::OP_INSERT, soil_name(present_name()), 8, 0);
		send_request(tskt_pkg::OP_SHOW, '0, 0, 0);
	endtask

	task automatic test_drain();
		rsp_idle_on = 1'b0;
		while (roster_count > 0) random_request(10, 75);
		rsp_idle_on = 1'b1;
		send_request(tskt_pkg::OP_SHOW, '0, 0, 0);
	endtask

	task automatic test_random_mix();
		for (int n = 0; n < 120; n++) begin
			if (n % 20 == 0) begin
				req_idle_on = ((n / 20) % 4) inside {0, 2};
				rsp_idle_on = ((n / 20) % 4) inside {0, 1};
			end
			random_request(45, 30);
		end
		req_idle_on = 1'b1;
		rsp_idle_on = 1'b1;
	endtask

	initial begin
		arst_n           = 1'b0;
		req_ch.valid     = 1'b0;
		req_ch.cmd       = '0;
		req_ch.key_word0 = '0;
		req_ch.key_word1 = '0;
		req_ch.key_word2 = '0;
		req_ch.hour_in   = '0;
		req_ch.minute_in = '0;
		repeat (10) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		test_empty_table();
		test_time_limits();
		test_name_ending();
		test_equal_times();
		test_fill_to_full();
		test_drain();
		test_random_mix();

		@(negedge clk);
		req_ch.valid <= 1'b0;
		while (reply_q.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (reply_q.size() != 0)
			report_mismatch("responses never arrived", 64'(reply_q.size()), 64'd0);

		$display("Sent %0d inserts, %0d deletes, %0d listings, %0d unused opcodes",
			op_counts[tskt_pkg::OP_INSERT], op_counts[tskt_pkg::OP_DELETE],
			op_counts[tskt_pkg::OP_SHOW], op_counts[OP_UNUSED]);
		$display("Checked %0d responses, %0d inserts rejected on a full table",
			results_seen, full_hits);
		if (errors == 0) begin
			$display("time_sorted_keyed_table_top verification clean");
		end else begin
			$display("time_sorted_keyed_table_top verification failed");
		end
		$finish;
	end

endmodule
